@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SSP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define SSP_ASSERT(lbl, clk, rstn, prop)
`define SSP_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ rtl/ssp_pkg.sv @@
package ssp_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HDR_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;
  localparam logic [1:0] ST_CRC_ERR = 2'd3;

  localparam logic [7:0]  HDR_FIRST = 8'hFF;
  localparam logic [7:0]  HDR_LAST  = 8'hFD;
  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam int unsigned OVERHEAD  = 7;
  localparam int unsigned MIN_FRAME = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  device_id;
    logic [7:0]  instruction;
    logic [15:0] param_count;
    logic [7:0]  param_zero;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
  } res_t;

endpackage

@@ rtl/ssp_in_stage.sv @@
module ssp_in_stage
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       v_r;
  logic [7:0] byte_r;

  assign in_ready   = !v_r || take;
  assign byte_valid = v_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

@@ rtl/ssp_parser.sv @@
`include "assert_macros.svh"

module ssp_parser
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       take,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [16:0] POS_HDR_END = 17'd3;
  localparam logic [16:0] POS_HDR_LST = 17'd2;
  localparam logic [16:0] POS_ID      = 17'd4;
  localparam logic [16:0] POS_LEN_LO  = 17'd5;
  localparam logic [16:0] POS_LEN_HI  = 17'd6;
  localparam logic [16:0] POS_INSTR   = 17'(OVERHEAD);
  localparam logic [16:0] POS_PARAM   = 17'(OVERHEAD + 1);
  localparam logic [16:0] CRC_OFFSET  = 17'(OVERHEAD - 2);
  localparam logic [15:0] LEN_MIN     = 16'(MIN_FRAME - OVERHEAD);

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  ins_r, ins_nxt;
  logic [7:0]  par_r [3];
  logic [7:0]  par_nxt [3];
  logic [7:0]  lo_r, lo_nxt;

  logic        fire;
  logic        clear;
  logic [15:0] crc_new;
  logic [16:0] crc_end;
  logic [16:0] par_off;
  logic [15:0] len_full;

  assign fire     = byte_valid && take;
  assign crc_new  = crc_upd(crc_r, byte_data);
  assign crc_end  = {1'b0, len_r} + CRC_OFFSET;
  assign par_off  = pos_r - POS_PARAM;
  assign len_full = {byte_data, len_r[7:0]};

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    id_nxt    = id_r;
    ins_nxt   = ins_r;
    par_nxt   = par_r;
    lo_nxt    = lo_r;
    clear     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (fire) begin
      if (pos_r < POS_HDR_END) begin
        if (byte_data != ((pos_r == POS_HDR_LST) ? HDR_LAST : HDR_FIRST)) begin
          res_valid  = 1'b1;
          res.status = ST_HDR_ERR;
          clear      = 1'b1;
        end else begin
          crc_nxt = crc_new;
          pos_nxt = pos_r + 17'd1;
        end
      end else if (pos_r < POS_INSTR) begin
        crc_nxt = crc_new;
        pos_nxt = pos_r + 17'd1;
        if (pos_r == POS_ID) begin
          id_nxt = byte_data;
        end else if (pos_r == POS_LEN_LO) begin
          len_nxt = {8'h00, byte_data};
        end else if (pos_r == POS_LEN_HI) begin
          len_nxt = len_full;
          if (len_full < LEN_MIN) begin
            res_valid  = 1'b1;
            res.status = ST_LEN_ERR;
            clear      = 1'b1;
          end
        end
      end else if (pos_r < crc_end) begin
        crc_nxt = crc_new;
        pos_nxt = pos_r + 17'd1;
        if (pos_r == POS_INSTR) begin
          ins_nxt = byte_data;
        end else if (par_off < 17'd3) begin
          par_nxt[par_off[1:0]] = byte_data;
        end
      end else if (pos_r == crc_end) begin
        lo_nxt  = byte_data;
        pos_nxt = pos_r + 17'd1;
      end else begin
        res_valid = 1'b1;
        clear     = 1'b1;
        if ({byte_data, lo_r} != crc_r) begin
          res.status = ST_CRC_ERR;
        end else begin
          res.status      = ST_OK;
          res.device_id   = id_r;
          res.instruction = ins_r;
          res.param_count = len_r - LEN_MIN;
          res.param_zero  = par_r[0];
          res.param_one   = par_r[1];
          res.param_two   = par_r[2];
        end
      end
    end
    if (clear) begin
      pos_nxt = '0;
      len_nxt = '0;
      crc_nxt = '0;
      id_nxt  = '0;
      ins_nxt = '0;
      par_nxt = '{default: '0};
      lo_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      crc_r <= '0;
      id_r  <= '0;
      ins_r <= '0;
      par_r <= '{default: '0};
      lo_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      id_r  <= id_nxt;
      ins_r <= ins_nxt;
      par_r <= par_nxt;
      lo_r  <= lo_nxt;
    end
  end

  `SSP_ASSERT(a_res_needs_fire, clk, rst_n, res_valid |-> fire)
  `SSP_ASSERT(a_restart_after_res, clk, rst_n, res_valid |=> (pos_r == '0 && crc_r == '0))
  `SSP_ASSERT(a_body_len_ok, clk, rst_n, (pos_r >= POS_INSTR) |-> (len_r >= LEN_MIN))
  `SSP_ASSERT(a_body_pos_ok, clk, rst_n, (pos_r >= POS_INSTR) |-> (pos_r <= crc_end + 17'd1))

endmodule

@@ rtl/servo_status_packet_parser_core.sv @@
// Channel | Dir | Ports                                   | Transfer when
// in      | in  | in_valid, in_ready, in_rx_byte          | in_valid & in_ready
// out     | out | out_valid, out_ready, out_status, out_* | out_valid & out_ready
//
// One byte per cycle sustained while results are taken; a result passes the input and result registers.
// Path: input register, byte-wide CRC update and framing compares, result register.
// Synchronous active-low reset clears the framing state and both stages.
// A stalled result holds the parser; the input register still takes one byte.
`include "assert_macros.svh"

module servo_status_packet_parser_core
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_device_id,
  output logic [7:0]  out_instruction,
  output logic [15:0] out_param_count,
  output logic [7:0]  out_param_zero,
  output logic [7:0]  out_param_one,
  output logic [7:0]  out_param_two
);

  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       res_valid;
  res_t       res;
  logic       out_valid_r;
  res_t       out_r;
  logic       err_zero;

  assign take = !out_valid_r || out_ready;

  ssp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ssp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_device_id   = out_r.device_id;
  assign out_instruction = out_r.instruction;
  assign out_param_count = out_r.param_count;
  assign out_param_zero  = out_r.param_zero;
  assign out_param_one   = out_r.param_one;
  assign out_param_two   = out_r.param_two;

  assign err_zero = ({out_device_id, out_instruction, out_param_count,
                      out_param_zero, out_param_one, out_param_two} == '0);

  `SSP_ASSERT_NORST(a_reset_empties, clk, !rst_n |=> !out_valid)
  `SSP_ASSERT(a_err_fields_zero, clk, rst_n, (out_valid && out_status != ST_OK) |-> err_zero)
  `SSP_ASSERT(a_full_stall_blocks, clk, rst_n, (byte_valid && !take) |-> !in_ready)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ssp_pkg::*;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_device_id;
  logic [7:0]  out_instruction;
  logic [15:0] out_param_count;
  logic [7:0]  out_param_zero;
  logic [7:0]  out_param_one;
  logic [7:0]  out_param_two;

  servo_status_packet_parser_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_device_id   (out_device_id),
    .out_instruction (out_instruction),
    .out_param_count (out_param_count),
    .out_param_zero  (out_param_zero),
    .out_param_one   (out_param_one),
    .out_param_two   (out_param_two)
  );

  // parser state mirror
  logic [16:0] frm_pos;
  logic [15:0] frm_len;
  logic [15:0] frm_crc;
  logic [7:0]  frm_id;
  logic [7:0]  frm_instr;
  logic [7:0]  frm_param [3];
  logic [7:0]  frm_crc_lo;

  res_t        parsed_frames[$];
  logic [7:0]  pkt[$];
  int          frames_predicted = 0;
  int          bytes_sent = 0;
  int          mismatch_count = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] crc16_8005(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  task clear_frame;
    frm_pos    = '0;
    frm_len    = '0;
    frm_crc    = '0;
    frm_id     = '0;
    frm_instr  = '0;
    frm_param  = '{default: 8'h00};
    frm_crc_lo = '0;
  endtask

  task end_frame(input res_t r);
    parsed_frames = {parsed_frames, r};
    frames_predicted++;
    clear_frame();
  endtask

  task parse_byte(input logic [7:0] b);
    logic [16:0] crc_end;
    res_t        r;
    r = '0;
    crc_end = {1'b0, frm_len} + 17'(OVERHEAD - 2);
    if (frm_pos < 3) begin
      if (b != ((frm_pos == 2) ? HDR_LAST : HDR_FIRST)) begin
        r.status = ST_HDR_ERR;
        end_frame(r);
        return;
      end
      frm_crc = crc16_8005(frm_crc, b);
      frm_pos++;
    end else if (frm_pos < OVERHEAD) begin
      frm_crc = crc16_8005(frm_crc, b);
      if (frm_pos == 4) begin
        frm_id = b;
      end else if (frm_pos == 5) begin
        frm_len = {8'h00, b};
      end else if (frm_pos == 6) begin
        frm_len[15:8] = b;
        if (frm_len < 3) begin
          r.status = ST_LEN_ERR;
          end_frame(r);
          return;
        end
      end
      frm_pos++;
    end else if (frm_pos < crc_end) begin
      frm_crc = crc16_8005(frm_crc, b);
      if (frm_pos == OVERHEAD) frm_instr = b;
      else if (frm_pos < OVERHEAD + 4) frm_param[frm_pos - OVERHEAD - 1] = b;
      frm_pos++;
    end else if (frm_pos == crc_end) begin
      frm_crc_lo = b;
      frm_pos++;
    end else begin
      if ({b, frm_crc_lo} != frm_crc) begin
        r.status = ST_CRC_ERR;
      end else begin
        r.status      = ST_OK;
        r.device_id   = frm_id;
        r.instruction = frm_instr;
        r.param_count = frm_len - 16'd3;
        r.param_zero  = frm_param[0];
        r.param_one   = frm_param[1];
        r.param_two   = frm_param[2];
      end
      end_frame(r);
    end
  endtask

  task report_mismatch(input string msg);
    if (mismatch_count < 200) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task check_result;
    res_t want;
    if (parsed_frames.size() == 0) begin
      report_mismatch($sformatf("result with none pending, status %0d", out_status));
      return;
    end
    want = parsed_frames.pop_front();
    compare_field("status", 16'(out_status), 16'(want.status));
    compare_field("device_id", 16'(out_device_id), 16'(want.device_id));
    compare_field("instruction", 16'(out_instruction), 16'(want.instruction));
    compare_field("param_count", out_param_count, want.param_count);
    compare_field("param_zero", 16'(out_param_zero), 16'(want.param_zero));
    compare_field("param_one", 16'(out_param_one), 16'(want.param_one));
    compare_field("param_two", 16'(out_param_two), 16'(want.param_two));
  endtask

  // result side: random stall, then take one transfer and check it
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 13) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result();
    end
  end

  task send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task send_pkt;
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  task load_packet(input logic [7:0] id, input logic [7:0] instr, input int n_params,
                   input int fill);
    logic [15:0] len;
    logic [15:0] crc;
    len = 16'(n_params + 3);
    pkt = {HDR_FIRST, HDR_FIRST, HDR_LAST, 8'($urandom_range(0, 255)), id, len[7:0],
           len[15:8], instr};
    for (int i = 0; i < n_params; i++) begin
      case (fill)
        FILL_ZERO: pkt = {pkt, 8'h00};
        FILL_ONES: pkt = {pkt, 8'hFF};
        default:   pkt = {pkt, 8'($urandom_range(0, 255))};
      endcase
    end
    crc = '0;
    foreach (pkt[i]) crc = crc16_8005(crc, pkt[i]);
    pkt = {pkt, crc[7:0], crc[15:8]};
  endtask

  task load_short(input logic [7:0] len_lo);
    pkt = {HDR_FIRST, HDR_FIRST, HDR_LAST, 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), len_lo, 8'h00};
  endtask

  task corrupt_byte(input int k);
    pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task test_header_mismatch;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    pkt = {8'h00};
    send_pkt();
    pkt = {HDR_FIRST, 8'h00};
    send_pkt();
    pkt = {HDR_FIRST, HDR_FIRST, HDR_FIRST};
    send_pkt();
    pkt = {HDR_FIRST, HDR_FIRST, 8'hFE, HDR_LAST};
    send_pkt();
  endtask

  task test_length_below_three;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    for (int n = 0; n < 3; n++) begin
      load_short(8'(n));
      send_pkt();
    end
  endtask

  task test_valid_frames;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_packet(8'h00, 8'h00, 0, FILL_ZERO);
    send_pkt();
    load_packet(8'hFF, 8'hFF, 1, FILL_ONES);
    send_pkt();
    tx_idle = 1'b1;
    load_packet(8'hFE, 8'h55, 2, FILL_RANDOM);
    send_pkt();
    load_packet(8'h01, 8'hAA, 3, FILL_ONES);
    send_pkt();
    rx_idle = 1'b1;
    load_packet(8'h80, 8'h7F, 5, FILL_RANDOM);
    send_pkt();
  endtask

  task test_crc_mismatch;
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    load_packet(8'h12, 8'h55, 2, FILL_RANDOM);
    corrupt_byte(pkt.size() - 1);
    send_pkt();
    load_packet(8'h34, 8'h03, 3, FILL_RANDOM);
    corrupt_byte(pkt.size() - 2);
    send_pkt();
    load_packet(8'h56, 8'h02, 4, FILL_RANDOM);
    corrupt_byte(8);
    send_pkt();
    load_packet(8'h78, 8'h01, 0, FILL_RANDOM);
    corrupt_byte(OVERHEAD);
    send_pkt();
  endtask

  // length 0x0101: high length byte set, low byte under three
  task test_long_frame;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    load_packet(8'h5A, 8'hA5, 254, FILL_RANDOM);
    send_pkt();
  endtask

  task test_random_traffic;
    int         byte_goal;
    int         frame_goal;
    int         kind;
    int         k;
    int         n;
    logic [7:0] want;
    logic [7:0] bad;
    byte_goal  = bytes_sent + 200;
    frame_goal = frames_predicted + 15;
    while (bytes_sent < byte_goal || frames_predicted < frame_goal) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
        load_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n, FILL_RANDOM);
        if (kind >= 65) begin
          k = $urandom_range(3, pkt.size() - 1);
          if (k == 5 || k == 6) k = OVERHEAD;
          corrupt_byte(k);
        end
      end else if (kind < 87) begin
        load_short(8'($urandom_range(0, 2)));
      end else if (kind < 94) begin
        n = $urandom_range(0, 2);
        pkt = {};
        for (int i = 0; i < n; i++) pkt = {pkt, HDR_FIRST};
        want = (n == 2) ? HDR_LAST : HDR_FIRST;
        do bad = 8'($urandom_range(0, 255)); while (bad == want);
        pkt = {pkt, bad};
      end else begin
        pkt = {};
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) pkt = {pkt, 8'($urandom_range(0, 255))};
      end
      send_pkt();
    end
  endtask

  task finish_run;
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (parsed_frames.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (parsed_frames.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", parsed_frames.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    clear_frame();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_header_mismatch();
    test_length_below_three();
    test_valid_frames();
    test_crc_mismatch();
    test_long_frame();
    test_random_traffic();
    finish_run();
  end

endmodule
